### design/rei_pkg.sv
// ----------------------------------------------------------------------------
// rei_pkg
// Shared types and constants of the ray / ellipsoid intersection pipeline.
// ----------------------------------------------------------------------------
package rei_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CENTER_Z      = 3'd2,
    CFG_SCALE_X       = 3'd3,
    CFG_SCALE_Y       = 3'd4,
    CFG_SCALE_Z       = 3'd5,
    CFG_SPHERE_RADIUS = 3'd6
  } cfg_idx_e;

  localparam logic [30:0] SCALE_RESET  = 31'd65536;
  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [30:0] DIST_MAX     = 31'h7FFF_FFFF;

  // object space divider: 6 lanes (3 origin, 3 direction), 32 quotient bits
  localparam int unsigned OBJ_LN  = 6;
  localparam int unsigned OBJ_QW  = 32;
  localparam int unsigned OBJ_BPS = 2;
  localparam int unsigned OBJ_ST  = OBJ_QW / OBJ_BPS;

  // square root: 64 result bits
  localparam int unsigned SQ_RW  = 64;
  localparam int unsigned SQ_BPS = 2;
  localparam int unsigned SQ_ST  = SQ_RW / SQ_BPS;

  // distance divider: 31 quotient bits
  localparam int unsigned QT_QW  = 31;
  localparam int unsigned QT_BPS = 2;
  localparam int unsigned QT_ST  = (QT_QW + QT_BPS - 1) / QT_BPS;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] scale_x;
    logic [30:0] scale_y;
    logic [30:0] scale_z;
    logic [30:0] sphere_radius;
  } cfg_t;

  // per-ray values that ride along with the discriminant and its root
  typedef struct packed {
    logic        miss;
    logic        hneg;
    logic [63:0] hmag;
    logic [63:0] amag;
  } side_t;

endpackage

### design/rei_obj_xform.sv
// ----------------------------------------------------------------------------
// rei_obj_xform
// Moves origin and direction into object space: center subtract for the
// origin, then a pipelined restoring divide by the axis scale, with saturation.
// ----------------------------------------------------------------------------
module rei_obj_xform
  import rei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [2:0][31:0] org_i,
  input  logic [2:0][31:0] dir_i,
  output logic             valid_o,
  output logic [2:0][31:0] pm_o,
  output logic [2:0][31:0] dm_o,
  output logic [2:0]       pn_o,
  output logic [2:0]       dn_o
);

  logic [2:0][31:0]        cen;
  logic [2:0][30:0]        scl;
  logic [OBJ_LN-1:0][30:0] dvs;
  logic [2:0][32:0]        rel;
  logic [2:0][32:0]        nrel;
  logic [OBJ_LN-1:0][31:0] mag;
  logic [63:0]             trial;

  logic [OBJ_LN-1:0][47:0] rem_d [OBJ_ST+1];
  logic [OBJ_LN-1:0][47:0] rem_q [OBJ_ST+1];
  logic [OBJ_LN-1:0][31:0] quo_d [OBJ_ST+1];
  logic [OBJ_LN-1:0][31:0] quo_q [OBJ_ST+1];
  logic [OBJ_LN-1:0]       neg_d;
  logic [OBJ_LN-1:0]       ovf_d;
  logic [OBJ_LN-1:0]       neg_q [OBJ_ST+1];
  logic [OBJ_LN-1:0]       ovf_q [OBJ_ST+1];
  logic                    vld_q [OBJ_ST+1];

  logic [OBJ_LN-1:0][31:0] fin_d;
  logic [OBJ_LN-1:0][31:0] fin_q;
  logic [OBJ_LN-1:0]       fneg_d;
  logic [OBJ_LN-1:0]       fneg_q;
  logic [OBJ_LN-1:0][31:0] cap;
  logic                    fvld_q;

  always_comb begin
    cen = {cfg_i.center_z, cfg_i.center_y, cfg_i.center_x};
    scl[0] = (cfg_i.scale_x == '0) ? 31'd1 : cfg_i.scale_x;
    scl[1] = (cfg_i.scale_y == '0) ? 31'd1 : cfg_i.scale_y;
    scl[2] = (cfg_i.scale_z == '0) ? 31'd1 : cfg_i.scale_z;
    for (int a = 0; a < 3; a++) begin
      dvs[a]     = scl[a];
      dvs[a + 3] = scl[a];
    end
  end

  // entry stage and divide steps
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rel[a]  = {org_i[a][31], org_i[a]} - {cen[a][31], cen[a]};
      nrel[a] = ~rel[a] + 33'd1;
      neg_d[a] = rel[a][32];
      mag[a]   = rel[a][32] ? nrel[a][31:0] : rel[a][31:0];
      neg_d[a + 3] = dir_i[a][31];
      mag[a + 3]   = dir_i[a][31] ? (~dir_i[a] + 32'd1) : dir_i[a];
    end
    for (int l = 0; l < OBJ_LN; l++) begin
      // quotient needs more than 32 bits
      ovf_d[l]    = {15'd0, mag[l][31:16]} >= dvs[l];
      rem_d[0][l] = {mag[l], 16'd0};
      quo_d[0][l] = '0;
    end
    trial = '0;
    for (int k = 1; k <= OBJ_ST; k++) begin
      for (int l = 0; l < OBJ_LN; l++) begin
        rem_d[k][l] = rem_q[k-1][l];
        quo_d[k][l] = quo_q[k-1][l];
        for (int j = 0; j < OBJ_BPS; j++) begin
          trial = 64'(dvs[l]) << (OBJ_QW - 1 - (k - 1) * OBJ_BPS - j);
          if ({16'd0, rem_d[k][l]} >= trial) begin
            rem_d[k][l] = rem_d[k][l] - trial[47:0];
            quo_d[k][l][OBJ_QW - 1 - (k - 1) * OBJ_BPS - j] = 1'b1;
          end
        end
      end
    end
  end

  // saturate: 2^31 for negative values, 2^31 - 1 for positive
  always_comb begin
    for (int l = 0; l < OBJ_LN; l++) begin
      cap[l]    = neg_q[OBJ_ST][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      fin_d[l]  = (ovf_q[OBJ_ST][l] || (quo_q[OBJ_ST][l] > cap[l])) ?
                  cap[l] : quo_q[OBJ_ST][l];
      fneg_d[l] = neg_q[OBJ_ST][l] && (fin_d[l] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= OBJ_ST; k++) vld_q[k] <= 1'b0;
      fvld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= OBJ_ST; k++) vld_q[k] <= vld_q[k-1];
      fvld_q <= vld_q[OBJ_ST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      neg_q[0] <= neg_d;
      ovf_q[0] <= ovf_d;
      for (int k = 1; k <= OBJ_ST; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      fin_q  <= fin_d;
      fneg_q <= fneg_d;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pm_o[a] = fin_q[a];
      dm_o[a] = fin_q[a + 3];
      pn_o[a] = fneg_q[a];
      dn_o[a] = fneg_q[a + 3];
    end
  end

  assign valid_o = fvld_q;

endmodule

### design/rei_quad.sv
// ----------------------------------------------------------------------------
// rei_quad
// Quadratic coefficients a, h, c from object space values and the
// discriminant h^2 - a*c, with 64 x 64 products cut into 32 x 32 parts.
// ----------------------------------------------------------------------------
module rei_quad
  import rei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [2:0][31:0] pm_i,
  input  logic [2:0][31:0] dm_i,
  input  logic [2:0]       pn_i,
  input  logic [2:0]       dn_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [127:0]     disc_o
);

  // stage 1: element products
  logic [2:0][63:0] pd_q, dd_q, pp_q;
  logic [2:0]       xn_q;
  logic [61:0]      rsq1_q;
  logic             v1_q;
  // stage 2: dot products
  logic [63:0]      amag2_q, psq2_q, hpos2_q, hngs2_q;
  logic [61:0]      rsq2_q;
  logic             v2_q;
  // stage 3: magnitudes and signs
  logic [63:0]      hmag3_q, cmag3_q, amag3_q;
  logic             hneg3_q, cneg3_q, zero3_q, v3_q;
  // stage 4: partial products
  logic [63:0]      hh00_q, hh01_q, hh11_q;
  logic [63:0]      ac00_q, ac01_q, ac10_q, ac11_q;
  logic [63:0]      hmag4_q, amag4_q;
  logic             hneg4_q, cneg4_q, zero4_q, v4_q;
  // stage 5: full products
  logic [127:0]     hh5_q, ac5_q;
  logic [63:0]      hmag5_q, amag5_q;
  logic             hneg5_q, cneg5_q, zero5_q, v5_q;
  // stage 6: discriminant
  logic [127:0]     disc6_q;
  side_t            side6_q;
  logic             v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        pd_q[a] <= 64'(pm_i[a]) * 64'(dm_i[a]);
        dd_q[a] <= 64'(dm_i[a]) * 64'(dm_i[a]);
        pp_q[a] <= 64'(pm_i[a]) * 64'(pm_i[a]);
        xn_q[a] <= pn_i[a] ^ dn_i[a];
      end
      rsq1_q <= 62'(cfg_i.sphere_radius) * 62'(cfg_i.sphere_radius);

      amag2_q <= dd_q[0] + dd_q[1] + dd_q[2];
      psq2_q  <= pp_q[0] + pp_q[1] + pp_q[2];
      hpos2_q <= (xn_q[0] ? 64'd0 : pd_q[0]) + (xn_q[1] ? 64'd0 : pd_q[1])
               + (xn_q[2] ? 64'd0 : pd_q[2]);
      hngs2_q <= (xn_q[0] ? pd_q[0] : 64'd0) + (xn_q[1] ? pd_q[1] : 64'd0)
               + (xn_q[2] ? pd_q[2] : 64'd0);
      rsq2_q  <= rsq1_q;

      hneg3_q <= hngs2_q > hpos2_q;
      hmag3_q <= (hngs2_q > hpos2_q) ? (hngs2_q - hpos2_q) : (hpos2_q - hngs2_q);
      cneg3_q <= {2'b00, rsq2_q} > psq2_q;
      cmag3_q <= ({2'b00, rsq2_q} > psq2_q) ? ({2'b00, rsq2_q} - psq2_q)
                                            : (psq2_q - {2'b00, rsq2_q});
      amag3_q <= amag2_q;
      zero3_q <= amag2_q == '0;

      hh00_q  <= 64'(hmag3_q[31:0])  * 64'(hmag3_q[31:0]);
      hh01_q  <= 64'(hmag3_q[31:0])  * 64'(hmag3_q[63:32]);
      hh11_q  <= 64'(hmag3_q[63:32]) * 64'(hmag3_q[63:32]);
      ac00_q  <= 64'(amag3_q[31:0])  * 64'(cmag3_q[31:0]);
      ac01_q  <= 64'(amag3_q[31:0])  * 64'(cmag3_q[63:32]);
      ac10_q  <= 64'(amag3_q[63:32]) * 64'(cmag3_q[31:0]);
      ac11_q  <= 64'(amag3_q[63:32]) * 64'(cmag3_q[63:32]);
      hmag4_q <= hmag3_q;
      amag4_q <= amag3_q;
      hneg4_q <= hneg3_q;
      cneg4_q <= cneg3_q;
      zero4_q <= zero3_q;

      // cross term of the square appears twice
      hh5_q   <= {hh11_q, hh00_q} + ({64'd0, hh01_q} << 33);
      ac5_q   <= {ac11_q, ac00_q} + ({64'd0, ac01_q} << 32) + ({64'd0, ac10_q} << 32);
      hmag5_q <= hmag4_q;
      amag5_q <= amag4_q;
      hneg5_q <= hneg4_q;
      cneg5_q <= cneg4_q;
      zero5_q <= zero4_q;

      disc6_q       <= cneg5_q ? (hh5_q + ac5_q) : (hh5_q - ac5_q);
      side6_q.miss  <= zero5_q || (!cneg5_q && (hh5_q < ac5_q));
      side6_q.hneg  <= hneg5_q;
      side6_q.hmag  <= hmag5_q;
      side6_q.amag  <= amag5_q;
    end
  end

  assign valid_o = v6_q;
  assign side_o  = side6_q;
  assign disc_o  = disc6_q;

endmodule

### design/rei_isqrt.sv
// ----------------------------------------------------------------------------
// rei_isqrt
// Pipelined digit-recurrence integer square root of the 128-bit
// discriminant, two result bits per stage.
// ----------------------------------------------------------------------------
module rei_isqrt
  import rei_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  side_t        side_i,
  input  logic [127:0] rad_i,
  output logic         valid_o,
  output side_t        side_o,
  output logic [63:0]  root_o
);

  logic [127:0] x_in  [SQ_ST];
  logic [67:0]  rm_in [SQ_ST];
  logic [63:0]  rt_in [SQ_ST];
  logic [127:0] x_d   [SQ_ST];
  logic [67:0]  rm_d  [SQ_ST];
  logic [63:0]  rt_d  [SQ_ST];
  logic [127:0] x_q   [SQ_ST];
  logic [67:0]  rm_q  [SQ_ST];
  logic [63:0]  rt_q  [SQ_ST];
  side_t        side_q [SQ_ST];
  logic         vld_q  [SQ_ST];
  logic [67:0]  trial;

  always_comb begin
    trial = '0;
    for (int k = 0; k < SQ_ST; k++) begin
      if (k == 0) begin
        x_in[k]  = rad_i;
        rm_in[k] = '0;
        rt_in[k] = '0;
      end else begin
        x_in[k]  = x_q[k-1];
        rm_in[k] = rm_q[k-1];
        rt_in[k] = rt_q[k-1];
      end
      x_d[k]  = x_in[k];
      rm_d[k] = rm_in[k];
      rt_d[k] = rt_in[k];
      for (int j = 0; j < SQ_BPS; j++) begin
        rm_d[k] = {rm_d[k][65:0], x_d[k][127:126]};
        x_d[k]  = {x_d[k][125:0], 2'b00};
        trial   = {2'b00, rt_d[k], 2'b01};
        if (rm_d[k] >= trial) begin
          rm_d[k] = rm_d[k] - trial;
          rt_d[k] = {rt_d[k][62:0], 1'b1};
        end else begin
          rt_d[k] = {rt_d[k][62:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_ST; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < SQ_ST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < SQ_ST; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < SQ_ST; k++) begin
        x_q[k]  <= x_d[k];
        rm_q[k] <= rm_d[k];
        rt_q[k] <= rt_d[k];
      end
    end
  end

  assign valid_o = vld_q[SQ_ST-1];
  assign side_o  = side_q[SQ_ST-1];
  assign root_o  = rt_q[SQ_ST-1];

endmodule

### design/rei_quot.sv
// ----------------------------------------------------------------------------
// rei_quot
// Picks the nearer positive root numerator and divides it by a in a
// pipelined restoring divider, Q16.16 result with saturation.
// ----------------------------------------------------------------------------
module rei_quot
  import rei_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [63:0] root_i,
  output logic        valid_o,
  output logic        hit_o,
  output logic [30:0] dist_o
);

  // root select stage
  logic        nv_q, nhit_q;
  logic [64:0] num_q;
  logic [63:0] namag_q;
  logic        found;
  logic [64:0] num;
  // range check stage
  logic        pv_q, phit_q, psat_q;
  logic [80:0] prem_q;
  logic [63:0] pamag_q;
  logic [80:0] nsh;
  // divide stages
  logic [80:0] rm_in [QT_ST];
  logic [30:0] qo_in [QT_ST];
  logic [63:0] am_in [QT_ST];
  logic [80:0] rm_d  [QT_ST];
  logic [30:0] qo_d  [QT_ST];
  logic [80:0] rm_q  [QT_ST];
  logic [30:0] qo_q  [QT_ST];
  logic [63:0] am_q  [QT_ST];
  logic        hit_q [QT_ST];
  logic        sat_q [QT_ST];
  logic        vld_q [QT_ST];
  logic [95:0] trial;
  int          b;

  always_comb begin
    found = 1'b1;
    num   = '0;
    if (side_i.miss) begin
      found = 1'b0;
    end else if (side_i.hneg && (side_i.hmag > root_i)) begin
      num = {1'b0, side_i.hmag - root_i};
    end else if (side_i.hneg) begin
      num = {1'b0, side_i.hmag} + {1'b0, root_i};
    end else if (root_i > side_i.hmag) begin
      num = {1'b0, root_i - side_i.hmag};
    end else begin
      found = 1'b0;
    end
  end

  assign nsh = {num_q, 16'd0};

  always_comb begin
    trial = '0;
    b     = 0;
    for (int k = 0; k < QT_ST; k++) begin
      if (k == 0) begin
        rm_in[k] = prem_q;
        qo_in[k] = '0;
        am_in[k] = pamag_q;
      end else begin
        rm_in[k] = rm_q[k-1];
        qo_in[k] = qo_q[k-1];
        am_in[k] = am_q[k-1];
      end
      rm_d[k] = rm_in[k];
      qo_d[k] = qo_in[k];
      for (int j = 0; j < QT_BPS; j++) begin
        b = QT_QW - 1 - k * QT_BPS - j;
        if (b >= 0) begin
          trial = 96'(am_in[k]) << b;
          if ({15'd0, rm_d[k]} >= trial) begin
            rm_d[k]    = rm_d[k] - trial[80:0];
            qo_d[k][b] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      pv_q <= 1'b0;
      for (int k = 0; k < QT_ST; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      nv_q     <= valid_i;
      pv_q     <= nv_q;
      vld_q[0] <= pv_q;
      for (int k = 1; k < QT_ST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nhit_q  <= found;
      num_q   <= num;
      namag_q <= side_i.amag;

      // quotient of 2^31 or more saturates
      psat_q  <= {15'd0, nsh} >= {1'b0, namag_q, 31'd0};
      phit_q  <= nhit_q;
      prem_q  <= nsh;
      pamag_q <= namag_q;

      hit_q[0] <= phit_q;
      sat_q[0] <= psat_q;
      for (int k = 1; k < QT_ST; k++) begin
        hit_q[k] <= hit_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
      for (int k = 0; k < QT_ST; k++) begin
        rm_q[k] <= rm_d[k];
        qo_q[k] <= qo_d[k];
        am_q[k] <= am_in[k];
      end
    end
  end

  assign valid_o = vld_q[QT_ST-1];
  assign hit_o   = hit_q[QT_ST-1];
  assign dist_o  = !hit_q[QT_ST-1] ? '0 :
                   sat_q[QT_ST-1] ? DIST_MAX : qo_q[QT_ST-1];

endmodule

### design/ray_ellipsoid_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersection_top
// Ray / ellipsoid hit test in Q16.16: object space transform, quadratic,
// square root and distance divide in one stalling pipeline.
//
//   port group    dir  handshake             payload
//   in_*          in   in_valid_i/in_stall_o  origin_*, direction_*
//   out_*         out  out_valid_o/out_stall_i hit_o, hit_distance_o
//   cfg_*         in   cfg_we_i              cfg_index_i, cfg_wdata_i
//
// One request per cycle while no result is held at a stalled output; the depth
// is set mostly by the 32-stage square root and the two 16-stage dividers
// (18 transform, 6 quadratic, 32 root, 18 divide, 1 output register).
// Reset clears the valid bits and loads the register reset values.
// A stall at the output freezes the whole pipeline; in_stall_o is high only
// while a result waits in the output register and out_stall_i is high.
// ----------------------------------------------------------------------------
module ray_ellipsoid_intersection_top
  import rei_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] direction_x_i,
  input  logic signed [31:0] direction_y_i,
  input  logic signed [31:0] direction_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [30:0]        hit_distance_o
);

  cfg_t             cfg_q;
  logic             en;
  logic [2:0][31:0] org, dir;
  logic             ov_valid;
  logic [2:0][31:0] pm, dm;
  logic [2:0]       pn, dn;
  logic             qd_valid;
  side_t            qd_side;
  logic [127:0]     disc;
  logic             sq_valid;
  side_t            sq_side;
  logic [63:0]      root;
  logic             qt_valid, qt_hit;
  logic [30:0]      qt_dist;
  logic             out_valid_q, hit_q;
  logic [30:0]      dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.center_z      <= '0;
      cfg_q.scale_x       <= SCALE_RESET;
      cfg_q.scale_y       <= SCALE_RESET;
      cfg_q.scale_z       <= SCALE_RESET;
      cfg_q.sphere_radius <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X:      cfg_q.center_x      <= cfg_wdata_i;
        CFG_CENTER_Y:      cfg_q.center_y      <= cfg_wdata_i;
        CFG_CENTER_Z:      cfg_q.center_z      <= cfg_wdata_i;
        CFG_SCALE_X:       cfg_q.scale_x       <= cfg_wdata_i[30:0];
        CFG_SCALE_Y:       cfg_q.scale_y       <= cfg_wdata_i[30:0];
        CFG_SCALE_Z:       cfg_q.scale_z       <= cfg_wdata_i[30:0];
        CFG_SPHERE_RADIUS: cfg_q.sphere_radius <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a result is held at the output
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  assign org = {origin_z_i, origin_y_i, origin_x_i};
  assign dir = {direction_z_i, direction_y_i, direction_x_i};

  rei_obj_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .org_i   (org),
    .dir_i   (dir),
    .valid_o (ov_valid),
    .pm_o    (pm),
    .dm_o    (dm),
    .pn_o    (pn),
    .dn_o    (dn)
  );

  rei_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (ov_valid),
    .pm_i    (pm),
    .dm_i    (dm),
    .pn_i    (pn),
    .dn_i    (dn),
    .valid_o (qd_valid),
    .side_o  (qd_side),
    .disc_o  (disc)
  );

  rei_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (qd_valid),
    .side_i  (qd_side),
    .rad_i   (disc),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (root)
  );

  rei_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .root_i  (root),
    .valid_o (qt_valid),
    .hit_o   (qt_hit),
    .dist_o  (qt_dist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= qt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= qt_hit;
      dist_q <= qt_dist;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;

  a_miss_zero_dist : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_distance_o == '0)
  ) else $error("miss with nonzero distance");

  a_stall_cause : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a held result");

  a_hold_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(qt_dist) && $stable(qt_valid))
  ) else $error("pipeline moved during output stall");

endmodule
